### rtl/tkd_pkg.sv
// ----------------------------------------------------------------------------
// tkd_pkg
// shared types and constants of the two-key debounce with long press block
// ----------------------------------------------------------------------------
package tkd_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT      = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0]  RELEASE_HOLD_RST = 8'd25;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd150;
    localparam logic [7:0]  LOCKOUT_RST      = 8'd40;

    // long press phase codes
    localparam logic [1:0] LP_NONE    = 2'd0;
    localparam logic [1:0] LP_ARMED   = 2'd1;
    localparam logic [1:0] LP_EMITTED = 2'd2;

    // event code offset of a long press
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_LONG_OFFSET = 3'd3;

    typedef struct packed {
        logic [7:0]  release_hold_ticks;
        logic [15:0] long_press_ticks;
        logic [7:0]  lockout_ticks;
    } cfg_t;

    typedef struct packed {
        logic       push;
        logic [2:0] key_event;
    } result_t;

endpackage

### rtl/tkd_cfg.sv
// ----------------------------------------------------------------------------
// tkd_cfg
// configuration registers, written through a plain write port
// ----------------------------------------------------------------------------
module tkd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tkd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tkd_pkg::CFG_DATA_W-1:0] cfg_data,
    output tkd_pkg::cfg_t                  cfg
);

    tkd_pkg::cfg_t cfg_reg;
    tkd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tkd_pkg::CFG_RELEASE_HOLD: cfg_next.release_hold_ticks = cfg_data[7:0];
                tkd_pkg::CFG_LONG_PRESS:   cfg_next.long_press_ticks   = cfg_data;
                tkd_pkg::CFG_LOCKOUT:      cfg_next.lockout_ticks      = cfg_data[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_hold_ticks <= tkd_pkg::RELEASE_HOLD_RST;
            cfg_reg.long_press_ticks   <= tkd_pkg::LONG_PRESS_RST;
            cfg_reg.lockout_ticks      <= tkd_pkg::LOCKOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/tkd_core.sv
// ----------------------------------------------------------------------------
// tkd_core
// debounce state and press timing, one tick per accepted request
// ----------------------------------------------------------------------------
module tkd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             key_a,
    input  logic             key_b,
    input  tkd_pkg::cfg_t    cfg,
    output tkd_pkg::result_t result
);

    logic [7:0]  lockout_reg;
    logic [7:0]  lockout_next;
    logic [7:0]  hold_a_reg;
    logic [7:0]  hold_a_next;
    logic [7:0]  hold_b_reg;
    logic [7:0]  hold_b_next;
    logic [1:0]  last_keys_reg;
    logic [1:0]  last_keys_next;
    logic [15:0] press_time_reg;
    logic [15:0] press_time_next;
    logic [1:0]  long_phase_reg;
    logic [1:0]  long_phase_next;
    logic [2:0]  ev;
    logic [1:0]  cur;
    logic        settled;

    always_comb
    begin
        lockout_next    = lockout_reg;
        hold_a_next     = hold_a_reg;
        hold_b_next     = hold_b_reg;
        last_keys_next  = last_keys_reg;
        press_time_next = press_time_reg;
        long_phase_next = long_phase_reg;
        ev              = tkd_pkg::EV_NONE;
        cur             = {key_b, key_a};
        settled         = 1'b0;

        if (lockout_reg != 8'd0)
        begin
            lockout_next = lockout_reg - 8'd1;
        end
        else
        begin
            // reload while pressed, count down after release
            if (key_a)
                hold_a_next = cfg.release_hold_ticks;
            else if (hold_a_reg != 8'd0)
                hold_a_next = hold_a_reg - 8'd1;
            if (key_b)
                hold_b_next = cfg.release_hold_ticks;
            else if (hold_b_reg != 8'd0)
                hold_b_next = hold_b_reg - 8'd1;

            settled = (hold_a_next == 8'd0 || hold_a_next == cfg.release_hold_ticks) &&
                      (hold_b_next == 8'd0 || hold_b_next == cfg.release_hold_ticks);

            if (settled)
            begin
                if (cur != 2'd0)
                begin
                    if (last_keys_reg != cur)
                    begin
                        press_time_next = 16'd0;
                        long_phase_next = tkd_pkg::LP_NONE;
                        last_keys_next  = cur;
                    end
                    else if (press_time_reg < cfg.long_press_ticks)
                    begin
                        press_time_next = press_time_reg + 16'd1;
                    end
                    else if (press_time_reg == cfg.long_press_ticks &&
                             long_phase_reg == tkd_pkg::LP_NONE)
                    begin
                        long_phase_next = tkd_pkg::LP_ARMED;
                    end
                    if (long_phase_next == tkd_pkg::LP_ARMED)
                    begin
                        ev              = 3'(last_keys_next) + tkd_pkg::EV_LONG_OFFSET;
                        long_phase_next = tkd_pkg::LP_EMITTED;
                        lockout_next    = cfg.lockout_ticks;
                    end
                end
                else if (last_keys_reg != 2'd0 && long_phase_reg == tkd_pkg::LP_NONE)
                begin
                    // short press on release
                    ev              = 3'(last_keys_reg);
                    last_keys_next  = 2'd0;
                    press_time_next = 16'd0;
                    long_phase_next = tkd_pkg::LP_NONE;
                    lockout_next    = cfg.lockout_ticks;
                end
                else if (long_phase_reg == tkd_pkg::LP_EMITTED)
                begin
                    last_keys_next  = 2'd0;
                    press_time_next = 16'd0;
                    long_phase_next = tkd_pkg::LP_NONE;
                    lockout_next    = cfg.lockout_ticks;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg    <= 8'd0;
            hold_a_reg     <= 8'd0;
            hold_b_reg     <= 8'd0;
            last_keys_reg  <= 2'd0;
            press_time_reg <= 16'd0;
            long_phase_reg <= tkd_pkg::LP_NONE;
        end
        else if (accept)
        begin
            lockout_reg    <= lockout_next;
            hold_a_reg     <= hold_a_next;
            hold_b_reg     <= hold_b_next;
            last_keys_reg  <= last_keys_next;
            press_time_reg <= press_time_next;
            long_phase_reg <= long_phase_next;
        end
    end

    assign result.push      = accept;
    assign result.key_event = ev;

`ifndef SYNTH
    // the armed phase never survives the tick that raised it
    a_no_armed_phase: assert property (@(posedge clk) disable iff (!rst_n)
        long_phase_reg != tkd_pkg::LP_ARMED)
        else $error("long phase left armed");

    a_lockout_counts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && lockout_reg != 8'd0 |=> lockout_reg == $past(lockout_reg) - 8'd1)
        else $error("lockout did not count down");

    a_event_locks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ev != tkd_pkg::EV_NONE |=> lockout_reg == $past(cfg.lockout_ticks))
        else $error("event did not start the lockout");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(press_time_reg) && $stable(hold_a_reg) && $stable(hold_b_reg))
        else $error("state moved without a request");
`endif

endmodule

### rtl/tkd_out.sv
// ----------------------------------------------------------------------------
// tkd_out
// result register between the core and the output channel
// ----------------------------------------------------------------------------
module tkd_out (
    input  logic             clk,
    input  logic             rst_n,
    input  tkd_pkg::result_t result,
    output logic             busy,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       key_event
);

    logic       valid_reg;
    logic       valid_next;
    logic [2:0] event_reg;

    // full and not being taken this cycle
    assign busy = valid_reg && out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (result.push)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result.push)
            event_reg <= result.key_event;
    end

    assign out_valid = valid_reg;
    assign key_event = event_reg;

endmodule

### rtl/two_key_debounce_long_press.sv
// ----------------------------------------------------------------------------
// two_key_debounce_long_press
// two-key debounce with short and long press events
// ----------------------------------------------------------------------------
// each request on the input channel (in_valid / in_stall) is one tick carrying
// the levels of key_a and key_b; every tick gives exactly one result on the
// output channel (out_valid / out_stall) with key_event: 0 none, 1-3 short
// press of key set 1-3, 4-6 long press of key set 1-3
// the result is registered on the edge that takes the request; throughput is
// one request per cycle while in_stall is low, set by the single result
// register, which takes a new result in the same cycle the old one is taken
// in_stall rises only while a result waits and out_stall is high
// the three registers are written through cfg_we / cfg_index / cfg_data;
// the user must do so only while no request is in flight, unenforced by
// the block; index 3 is ignored; reset clears all debounce state and the
// result valid flag, and loads hold 25, long press 150 and lockout 40 ticks
// ----------------------------------------------------------------------------
module two_key_debounce_long_press (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           key_a,
    input  logic                           key_b,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     key_event,
    input  logic                           cfg_we,
    input  logic [tkd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tkd_pkg::CFG_DATA_W-1:0] cfg_data
);

    tkd_pkg::cfg_t    cfg;
    tkd_pkg::result_t result;
    logic             busy;
    logic             accept;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    tkd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tkd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .key_a  (key_a),
        .key_b  (key_b),
        .cfg    (cfg),
        .result (result)
    );

    tkd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_event (key_event)
    );

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench for two_key_debounce_long_press
// Drives key ticks through the valid/stall request channel. Both sides idle
// at random. An internal model of the debounce, press timer and lockout
// predicts every key_event, and each result is checked in order against it.
// The register settings are changed between phases: reset values, both
// extremes, fixed small values and random small values.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [tkd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int                            STALL_LIMIT    = 5000;
    localparam int                            IDLE_PERCENT   = 28;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic                           key_a     = 1'b0;
    logic                           key_b     = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [2:0]                     key_event;
    logic                           cfg_we    = 1'b0;
    logic [tkd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tkd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // register copies
    logic [7:0]  hold_reload;
    logic [15:0] long_limit;
    logic [7:0]  lockout_len;

    // debounce state copies
    logic [7:0]  lock_left;
    logic [7:0]  hold_a_left;
    logic [7:0]  hold_b_left;
    logic [1:0]  held_set;
    logic [15:0] press_ticks;
    logic [1:0]  press_phase;

    logic [2:0]  events_due[$];
    int          ticks_sent  = 0;
    int          mismatches  = 0;
    int          quiet_count = 0;
    bit          calm        = 1'b0;

    two_key_debounce_long_press dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .key_a     (key_a),
        .key_b     (key_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_event (key_event),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // works out the event of one tick and advances the state copies
    function automatic logic [2:0] next_key_event(input logic a, input logic b);
        logic [2:0] ev;
        logic [1:0] cur;
        ev = tkd_pkg::EV_NONE;
        if (lock_left != 8'd0)
        begin
            lock_left = lock_left - 8'd1;
            return ev;
        end
        cur = {b, a};
        if (a)
            hold_a_left = hold_reload;
        else if (hold_a_left != 8'd0)
            hold_a_left = hold_a_left - 8'd1;
        if (b)
            hold_b_left = hold_reload;
        else if (hold_b_left != 8'd0)
            hold_b_left = hold_b_left - 8'd1;
        // no decision while a released key is still in its hold
        if ((hold_a_left == 8'd0 || hold_a_left == hold_reload) &&
            (hold_b_left == 8'd0 || hold_b_left == hold_reload))
        begin
            if (cur != 2'd0)
            begin
                if (held_set != cur)
                begin
                    press_ticks = 16'd0;
                    press_phase = tkd_pkg::LP_NONE;
                    held_set    = cur;
                end
                else if (press_ticks < long_limit)
                    press_ticks = press_ticks + 16'd1;
                else if (press_ticks == long_limit && press_phase == tkd_pkg::LP_NONE)
                    press_phase = tkd_pkg::LP_ARMED;
                if (press_phase == tkd_pkg::LP_ARMED)
                begin
                    ev          = {1'b0, held_set} + tkd_pkg::EV_LONG_OFFSET;
                    press_phase = tkd_pkg::LP_EMITTED;
                    lock_left   = lockout_len;
                end
            end
            else if (held_set != 2'd0 && press_phase == tkd_pkg::LP_NONE)
            begin
                ev          = {1'b0, held_set};
                held_set    = 2'd0;
                press_ticks = 16'd0;
                press_phase = tkd_pkg::LP_NONE;
                lock_left   = lockout_len;
            end
            else if (press_phase == tkd_pkg::LP_EMITTED)
            begin
                held_set    = 2'd0;
                press_ticks = 16'd0;
                press_phase = tkd_pkg::LP_NONE;
                lock_left   = lockout_len;
            end
        end
        return ev;
    endfunction

    task automatic note_failure(input string what, input logic [2:0] want,
                                input logic [2:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("tb: %s expected %0d got %0d", what, want, got);
    endtask

    // result side: random stall and in-order check
    always @(posedge clk)
    begin
        logic [2:0] want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (events_due.size() == 0)
                note_failure("unexpected result", tkd_pkg::EV_NONE, key_event);
            else
            begin
                want = events_due.pop_front();
                if (key_event !== want)
                    note_failure("key_event mismatch", want, key_event);
            end
        end
        if (rst_n)
            out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
            if (quiet_count >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // one tick request, held until accepted
    task automatic send_tick(input logic [1:0] keys);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_a    <= keys[0];
        key_b    <= keys[1];
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        events_due.push_back(next_key_event(keys[0], keys[1]));
        ticks_sent++;
    endtask

    task automatic hold_keys(input logic [1:0] keys, input int n);
        repeat (n) send_tick(keys);
    endtask

    // sender pauses until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_register(input logic [tkd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tkd_pkg::CFG_DATA_W-1:0] data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            tkd_pkg::CFG_RELEASE_HOLD: hold_reload = data[7:0];
            tkd_pkg::CFG_LONG_PRESS:   long_limit  = data;
            tkd_pkg::CFG_LOCKOUT:      lockout_len = data[7:0];
            default:                   ;
        endcase
        cfg_we <= 1'b0;
    endtask

    // upper data bits of the narrow registers are random and must be dropped
    task automatic apply_setting(input logic [7:0] hold, input logic [15:0] lim,
                                 input logic [7:0] lock);
        set_register(tkd_pkg::CFG_RELEASE_HOLD, {8'($urandom), hold});
        set_register(tkd_pkg::CFG_LONG_PRESS, lim);
        set_register(tkd_pkg::CFG_LOCKOUT, {8'($urandom), lock});
    endtask

    task automatic test_short_and_long_presses();
        apply_setting(8'd1, 16'd3, 8'd2);
        hold_keys(2'd1, 2);
        hold_keys(2'd0, 5);
        hold_keys(2'd2, 6);
        hold_keys(2'd0, 5);
        hold_keys(2'd3, 2);
        hold_keys(2'd0, 5);
    endtask

    task automatic test_release_hold();
        apply_setting(8'd3, 16'd6, 8'd1);
        hold_keys(2'd3, 2);
        hold_keys(2'd1, 2);
        hold_keys(2'd0, 6);
    endtask

    task automatic test_threshold_lowered();
        apply_setting(8'd1, 16'd10, 8'd2);
        hold_keys(2'd1, 6);
        set_register(tkd_pkg::CFG_LONG_PRESS, 16'd2);
        hold_keys(2'd1, 4);
        hold_keys(2'd0, 5);
    endtask

    task automatic test_out_of_range_registers();
        apply_setting(8'd0, 16'd0, 8'd0);
        hold_keys(2'd3, 3);
        hold_keys(2'd0, 2);
        hold_keys(2'd2, 1);
        hold_keys(2'd0, 2);
        // write to the unused index must change nothing
        set_register(CFG_UNUSED_IDX, 16'hFFFF);
        hold_keys(2'd1, 3);
        hold_keys(2'd0, 2);
    endtask

    // one press gesture: mostly clean presses, some broken ones and noise
    task automatic run_gesture();
        int kind;
        int dur;
        int cap;
        logic [1:0] keys;
        kind = $urandom_range(99);
        keys = 2'($urandom_range(1, 3));
        if (kind < 80)
        begin
            cap = (long_limit > 60) ? 60 : ((long_limit == 0) ? 1 : int'(long_limit));
            if (long_limit <= 300 && $urandom_range(1))
                dur = int'(long_limit) + 2 + $urandom_range(0, 3);
            else
                dur = $urandom_range(1, cap);
            hold_keys(keys, dur);
            hold_keys(2'd0, int'(hold_reload) + int'(lockout_len) + $urandom_range(1, 4));
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(2, 5))
                hold_keys(2'($urandom_range(0, 3)),
                          $urandom_range(1, int'(hold_reload) + 2));
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                send_tick(2'($urandom));
        end
        if ($urandom_range(99) < 5)
            drain_results();
    endtask

    task automatic run_phase(input logic [7:0] hold, input logic [15:0] lim,
                             input logic [7:0] lock, input int budget);
        int start;
        apply_setting(hold, lim, lock);
        start = ticks_sent;
        while (ticks_sent - start < budget)
            run_gesture();
    endtask

    task automatic test_random_gestures();
        run_phase(8'd1, 16'd1, 8'd0, 200);
        calm = 1'b1;
        run_phase(8'd3, 16'd5, 8'd2, 250);
        calm = 1'b0;
        run_phase(8'd0, 16'd0, 8'd0, 150);
        run_phase(tkd_pkg::RELEASE_HOLD_RST, tkd_pkg::LONG_PRESS_RST,
                  tkd_pkg::LOCKOUT_RST, 400);
        run_phase(8'd255, 16'd65535, 8'd255, 500);
        repeat (3)
            run_phase(8'($urandom_range(1, 8)), 16'($urandom_range(1, 20)),
                      8'($urandom_range(0, 10)), 170);
    endtask

    initial
    begin
        hold_reload = tkd_pkg::RELEASE_HOLD_RST;
        long_limit  = tkd_pkg::LONG_PRESS_RST;
        lockout_len = tkd_pkg::LOCKOUT_RST;
        lock_left   = 8'd0;
        hold_a_left = 8'd0;
        hold_b_left = 8'd0;
        held_set    = 2'd0;
        press_ticks = 16'd0;
        press_phase = tkd_pkg::LP_NONE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_and_long_presses();
        test_release_hold();
        test_threshold_lowered();
        test_out_of_range_registers();
        test_random_gestures();
        drain_results();

        if (mismatches == 0 && events_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
